// File: sv/pressure_temperature_compensation_unit_defines.svh
// Assertion macros for the compensation unit.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
// Property P must hold on every edge outside reset.
`define PTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A implies B on the next edge.
`define PTC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// File: sv/ptc_pkg.sv
// Package: types, constants and helpers of the compensation unit.
`default_nettype none
package ptc_pkg;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivPerStage = 2;
  localparam int unsigned DivStages = DivSteps / DivPerStage;

  typedef enum logic [1:0] {
    RegTemp  = 2'd0,
    RegPressA = 2'd1,
    RegPressB = 2'd2,
    RegPressC = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [15:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } cal_t;

  typedef struct packed {
    logic [19:0] temp_adc;
    logic [19:0] press_adc;
  } in_t;

  typedef struct packed {
    logic [31:0] fine_temperature;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pascal;
    logic        pressure_invalid;
  } out_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

  // Low 32 bits of the product only.
  function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
    mulw = a * b;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction
endpackage
`default_nettype wire

// File: sv/ptc_stream_if.sv
// Valid/ready stream interface with parametric payload.
`default_nettype none
interface ptc_stream_if #(parameter int unsigned Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ptc_regs.sv
// APB register file holding the calibration words.
`default_nettype none
module ptc_regs import ptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cal_t             cal_o
);
  logic [47:0] regs_q [4];
  logic        wr_en;
  logic [1:0]  idx;
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) regs_q[i] <= '0;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[47:0];
    end
  end

  always_comb begin
    prdata = (paddr[2:0] == 3'd0) ? {16'd0, regs_q[idx]} : 64'd0;
  end

  always_comb begin
    cal_o.t1 = regs_q[RegTemp][15:0];
    cal_o.t2 = sx16(regs_q[RegTemp][31:16]);
    cal_o.t3 = sx16(regs_q[RegTemp][47:32]);
    cal_o.p1 = regs_q[RegPressA][15:0];
    cal_o.p2 = sx16(regs_q[RegPressA][31:16]);
    cal_o.p3 = sx16(regs_q[RegPressA][47:32]);
    cal_o.p4 = sx16(regs_q[RegPressB][15:0]);
    cal_o.p5 = sx16(regs_q[RegPressB][31:16]);
    cal_o.p6 = sx16(regs_q[RegPressB][47:32]);
    cal_o.p7 = sx16(regs_q[RegPressC][15:0]);
    cal_o.p8 = sx16(regs_q[RegPressC][31:16]);
    cal_o.p9 = sx16(regs_q[RegPressC][47:32]);
  end
endmodule
`default_nettype wire

// File: sv/ptc_front.sv
// Front stages: temperature and divisor/dividend preparation.
`default_nettype none
module ptc_front import ptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  in_t              in_i,
  input  cal_t             cal_i,
  output logic             valid_o,
  output logic [31:0]      fine_o,
  output logic [31:0]      centi_o,
  output logic [31:0]      dividend_o,
  output logic [31:0]      divisor_o,
  output logic             big_o
);
  // stage 1: temperature products
  logic [31:0] a1_d, dd_d, d12_d, a1_q, d12_q;
  logic [19:0] rp1_q;
  logic        v1_q;
  // stage 2
  logic [31:0] fine2_q; logic [19:0] rp2_q; logic v2_q;
  // stage 3
  logic [31:0] fine3_q, v13_q, sq3_q; logic [19:0] rp3_q; logic v3_q;
  // stage 4
  logic [31:0] fine4_q, centi4_q, t6_q, t5_q, t3_q, t2_q; logic [19:0] rp4_q; logic v4_q;
  // stage 5
  logic [31:0] fine5_q, centi5_q, vv2_q, vv1_q; logic [19:0] rp5_q; logic v5_q;
  // stage 6
  logic [31:0] fine6_q, centi6_q, vv2b_q, m6_q; logic v6_q;
  // stage 7
  logic [31:0] fine7_q, centi7_q, pres7_q, div7_q; logic v7_q;

  logic [31:0] rt, v1f, qf;
  always_comb begin
    rt = 32'(in_i.temp_adc);
    a1_d = asr(mulw((rt >> 3) - (32'(cal_i.t1) << 1), cal_i.t2), 11);
    dd_d = (rt >> 4) - 32'(cal_i.t1);
    d12_d = asr(mulw(dd_d, dd_d), 12);
    v1f = asr(fine2_q, 1) - 32'd64000;
    qf = asr(v1f, 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <= '0;
    end else if (en_i) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <=
        {valid_i, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a1_d; d12_q <= d12_d; rp1_q <= in_i.press_adc;
      fine2_q <= a1_q + asr(mulw(d12_q, cal_i.t3), 14);
      rp2_q <= rp1_q;
      fine3_q <= fine2_q; v13_q <= v1f; sq3_q <= mulw(qf, qf); rp3_q <= rp2_q;
      fine4_q <= fine3_q; rp4_q <= rp3_q;
      centi4_q <= asr(mulw(fine3_q, 32'd5) + 32'd128, 8);
      t6_q <= mulw(asr(sq3_q, 11), cal_i.p6);
      t5_q <= mulw(v13_q, cal_i.p5) << 1;
      t3_q <= asr(mulw(cal_i.p3, asr(sq3_q, 13)), 3);
      t2_q <= asr(mulw(cal_i.p2, v13_q), 1);
      fine5_q <= fine4_q; centi5_q <= centi4_q; rp5_q <= rp4_q;
      vv2_q <= asr(t6_q + t5_q, 2) + (cal_i.p4 << 16);
      vv1_q <= asr(t3_q + t2_q, 18);
      fine6_q <= fine5_q; centi6_q <= centi5_q;
      vv2b_q <= (32'd1048576 - 32'(rp5_q)) - asr(vv2_q, 12);
      m6_q <= asr(mulw(32'd32768 + vv1_q, 32'(cal_i.p1)), 15);
      fine7_q <= fine6_q; centi7_q <= centi6_q;
      pres7_q <= mulw(vv2b_q, 32'd3125);
      div7_q <= m6_q;
    end
  end

  assign valid_o = v7_q;
  assign fine_o = fine7_q;
  assign centi_o = centi7_q;
  assign big_o = pres7_q[31];
  assign dividend_o = pres7_q[31] ? pres7_q : (pres7_q << 1);
  assign divisor_o = div7_q;
endmodule
`default_nettype wire

// File: sv/ptc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
`default_nettype none
module ptc_div import ptc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  input  wire logic   big_i,
  input  wire logic [63:0] side_i,
  output logic        valid_o,
  output logic [31:0] quot_o,
  output logic        big_o,
  output logic        zero_o,
  output logic [63:0] side_o
);
  logic [31:0] rem_q [DivStages+1];
  logic [31:0] num_q [DivStages+1];
  logic [31:0] den_q [DivStages+1];
  logic [DivStages:0] vld_q, big_q;
  logic [63:0] side_q [DivStages+1];

  always_comb begin
    rem_q[0] = '0; num_q[0] = num_i; den_q[0] = den_i;
    vld_q[0] = valid_i; big_q[0] = big_i; side_q[0] = side_i;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_st
    logic [31:0] r_n, n_n;
    logic [32:0] tr;
    always_comb begin
      r_n = rem_q[s]; n_n = num_q[s]; tr = '0;
      for (int k = 0; k < DivPerStage; k++) begin
        tr = {r_n, n_n[31]};
        n_n = {n_n[30:0], 1'b0};
        if (tr >= {1'b0, den_q[s]}) begin
          tr = tr - {1'b0, den_q[s]};
          n_n[0] = 1'b1;
        end
        r_n = tr[31:0];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else if (en_i) vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r_n; num_q[s+1] <= n_n; den_q[s+1] <= den_q[s];
        big_q[s+1] <= big_q[s]; side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[DivStages];
  assign quot_o = num_q[DivStages];
  assign big_o = big_q[DivStages];
  assign zero_o = (den_q[DivStages] == '0);
  assign side_o = side_q[DivStages];
endmodule
`default_nettype wire

// File: sv/ptc_back.sv
// Back stages: second-order pressure correction.
`default_nettype none
module ptc_back import ptc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  wire logic [31:0] quot_i,
  input  wire logic   big_i,
  input  wire logic   zero_i,
  input  wire logic [63:0] side_i,
  input  cal_t        cal_i,
  output logic        valid_o,
  output out_t        out_o
);
  logic [31:0] p1_q, s1_q, p2_q, a2_q, b2_q, p3_q, c3_q;
  logic [63:0] sd1_q, sd2_q, sd3_q;
  logic z1_q, z2_q, z3_q, v1_q, v2_q, v3_q;
  logic [31:0] pres_d;

  always_comb pres_d = big_i ? (quot_i << 1) : quot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) {v1_q, v2_q, v3_q} <= '0;
    else if (en_i) {v1_q, v2_q, v3_q} <= {valid_i, v1_q, v2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= pres_d; z1_q <= zero_i; sd1_q <= side_i;
      s1_q <= mulw(pres_d >> 3, pres_d >> 3) >> 13;
      p2_q <= p1_q; z2_q <= z1_q; sd2_q <= sd1_q;
      a2_q <= asr(mulw(cal_i.p9, s1_q), 12);
      b2_q <= asr(mulw(p1_q >> 2, cal_i.p8), 13);
      p3_q <= p2_q; z3_q <= z2_q; sd3_q <= sd2_q;
      c3_q <= asr(a2_q + b2_q + cal_i.p7, 4);
    end
  end

  assign valid_o = v3_q;
  always_comb begin
    out_o.fine_temperature = sd3_q[63:32];
    out_o.temperature_centi = sd3_q[31:0];
    out_o.pressure_invalid = z3_q;
    out_o.pressure_pascal = z3_q ? 32'd0 : p3_q + c3_q;
  end
endmodule
`default_nettype wire

// File: sv/pressure_temperature_compensation_unit.sv
// Top level of the pressure and temperature compensation unit.
// Usage:
//  - in_if (sink): raw_temperature and raw_pressure, one transaction per sample.
//  - out_if (source): fine_temperature, temperature_centi, pressure_pascal,
//    pressure_invalid; exactly one result transaction per input transaction.
//  - APB port: four 48-bit calibration registers at byte addresses 0, 8, 16, 24,
//    to be written only while the unit is idle; the block does not enforce this.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: 7 front stages, 16 divider stages of two quotient bits each (the
//  32-step restoring divider), 3 correction stages, and the output register.
// Stall: the whole pipeline holds while the output register is full and not
//  taken; in_if.ready is low only then, so nothing is lost or repeated.
// Reset: asynchronous, active low; clears valid bits and calibration to zero.
`default_nettype none
`include "pressure_temperature_compensation_unit_defines.svh"
module pressure_temperature_compensation_unit import ptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ptc_stream_if.sink       in_if,
  ptc_stream_if.source     out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  cal_t cal;
  in_t  in_data;
  logic en;
  logic fv; logic [31:0] ffine, fcenti, fnum, fden; logic fbig;
  logic dv; logic [31:0] dq; logic dbig, dz; logic [63:0] dside;
  logic bv; out_t bout;
  logic ov_q; out_t out_q;

  ptc_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .pready, .cal_o(cal));

  // Pipeline advances unless the output register holds an untaken result.
  assign en = !ov_q || out_if.ready;
  assign in_if.ready = en;
  assign in_data = in_t'(in_if.data);

  ptc_front u_front (.clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid),
    .in_i(in_data), .cal_i(cal), .valid_o(fv), .fine_o(ffine), .centi_o(fcenti),
    .dividend_o(fnum), .divisor_o(fden), .big_o(fbig));

  ptc_div u_div (.clk_i, .rst_ni, .en_i(en), .valid_i(fv), .num_i(fnum),
    .den_i(fden), .big_i(fbig), .side_i({ffine, fcenti}), .valid_o(dv),
    .quot_o(dq), .big_o(dbig), .zero_o(dz), .side_o(dside));

  ptc_back u_back (.clk_i, .rst_ni, .en_i(en), .valid_i(dv), .quot_i(dq),
    .big_i(dbig), .zero_i(dz), .side_i(dside), .cal_i(cal), .valid_o(bv),
    .out_o(bout));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= bv;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= bout;
  end

  assign out_if.valid = ov_q;
  assign out_if.data = out_q;

  `PTC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.data), "stalled result changed")
  `PTC_ASSERT(a_zero, clk_i, rst_ni, !out_if.valid || !out_q.pressure_invalid || out_q.pressure_pascal == 32'd0, "invalid pressure not zero")
  `PTC_ASSERT(a_ready, clk_i, rst_ni, in_if.ready == (!out_if.valid || out_if.ready), "ready mismatch")
endmodule
`default_nettype wire
